>>> hdl/sgcdf_pkg.sv
// ----------------------------------------------------------------------------
// sgcdf_pkg
// Shared widths, types, command codes and helper functions of the signed gcd
// fold unit.
// ----------------------------------------------------------------------------
package sgcdf_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAG_W      = DATA_WIDTH + 1;
  localparam int CNT_W      = $clog2(MAG_W + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic        [MAG_W-1:0]      mag_t;
  typedef logic        [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    CMD_VALUE   = 2'd0,
    CMD_SET_DIV = 2'd1,
    CMD_LIST    = 2'd2
  } cmd_t;

  // request into the gcd engine
  typedef struct packed {
    logic start;
    mag_t a;
    mag_t b;
  } gcd_req_t;

  // response from the gcd engine
  typedef struct packed {
    logic done;
    mag_t result;
  } gcd_rsp_t;

  // sign-extend a data word by one bit
  function automatic mag_t sext(input data_t v);
    return {v[DATA_WIDTH-1], v};
  endfunction

  // magnitude of a two's complement pattern one bit wider than the data
  function automatic mag_t mag_of(input mag_t v);
    return v[MAG_W-1] ? (~v + mag_t'(1)) : v;
  endfunction

endpackage

>>> hdl/sgcdf_in_if.sv
// ----------------------------------------------------------------------------
// sgcdf_in_if
// Request channel of the signed gcd fold unit.
// ----------------------------------------------------------------------------
interface sgcdf_in_if;
  import sgcdf_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  data_t       operand;
  logic        first_of_list;
  logic        last_of_list;

  modport source (output valid, cmd, operand, first_of_list, last_of_list, input ready);
  modport sink   (input valid, cmd, operand, first_of_list, last_of_list, output ready);
endinterface

>>> hdl/sgcdf_out_if.sv
// ----------------------------------------------------------------------------
// sgcdf_out_if
// Result channel of the signed gcd fold unit.
// ----------------------------------------------------------------------------
interface sgcdf_out_if;
  import sgcdf_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [MAG_W-1:0] divisor_result;

  modport source (output valid, divisor_result, input ready);
  modport sink   (input valid, divisor_result, output ready);
endinterface

>>> hdl/sgcdf_gcd_engine.sv
// ----------------------------------------------------------------------------
// sgcdf_gcd_engine
// Iterative binary gcd of two magnitudes around one shared subtractor.
// ----------------------------------------------------------------------------
module sgcdf_gcd_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  sgcdf_pkg::gcd_req_t req,
  output sgcdf_pkg::gcd_rsp_t rsp
);
  import sgcdf_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE,
    E_REDUCE,
    E_RESTORE
  } estate_t;

  estate_t state_r;
  mag_t    a_r;
  mag_t    b_r;
  cnt_t    k_r;
  logic    done_r;

  logic    a_ge_b;
  mag_t    diff;

  // shared subtractor: larger minus smaller
  always_comb begin
    a_ge_b = (a_r >= b_r);
    diff   = a_ge_b ? (a_r - b_r) : (b_r - a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        E_IDLE: begin
          if (req.start) begin
            k_r <= '0;
            if (req.b == '0) begin
              b_r    <= '0;
              done_r <= 1'b1;
            end else if (req.a == '0) begin
              b_r    <= req.b;
              done_r <= 1'b1;
            end else begin
              a_r     <= req.a;
              b_r     <= req.b;
              state_r <= E_REDUCE;
            end
          end
        end
        E_REDUCE: begin
          if (a_r == '0) begin
            state_r <= E_RESTORE;
          end else if (!a_r[0] && !b_r[0]) begin
            a_r <= a_r >> 1;
            b_r <= b_r >> 1;
            k_r <= k_r + cnt_t'(1);
          end else if (!a_r[0]) begin
            a_r <= a_r >> 1;
          end else if (!b_r[0]) begin
            b_r <= b_r >> 1;
          end else if (a_ge_b) begin
            a_r <= diff >> 1;
          end else begin
            b_r <= diff >> 1;
          end
        end
        E_RESTORE: begin
          // put back the common factors of two, one per cycle
          if (k_r == '0) begin
            done_r  <= 1'b1;
            state_r <= E_IDLE;
          end else begin
            b_r <= b_r << 1;
            k_r <= k_r - cnt_t'(1);
          end
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = b_r;

endmodule

>>> hdl/signed_gcd_fold_unit_core.sv
// Divisor, unused and load-only list requests are handled in the idle state; a gcd
// request runs the reduce steps and restore shifts of the binary gcd loop of the
// engine, and skips both if an operand is zero.
// One request in flight; a finished result waits in the output register while
// the next request is taken, and the input stalls until a blocked result drains.
// Reset (synchronous, rst_n low) clears stored divisor and running value.
// ----------------------------------------------------------------------------
// signed_gcd_fold_unit_core
// Signed gcd with a stored divisor and list folding of a running value.
// ----------------------------------------------------------------------------
module signed_gcd_fold_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  sgcdf_in_if.sink    in_ch,
  sgcdf_out_if.source out_ch
);
  import sgcdf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t   state_r;
  data_t    stored_divisor_r;
  mag_t     running_value_r;
  logic     emit_r;
  logic     out_valid_r;
  mag_t     out_data_r;

  logic     accept;
  logic     slot_free;
  logic     out_load;
  cmd_t     cmd;
  gcd_req_t gcd_req;
  gcd_rsp_t gcd_rsp;

  // Take a request only when the engine and the sequencer are idle.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.cmd);

  // The output register can take a new result if it is empty or being drained.
  assign slot_free = !out_valid_r || out_ch.ready;

  // Load the output register: a lone list element, a finished gcd that is to
  // be emitted, or a held result once the slot frees.
  assign out_load = slot_free &&
                    ((accept && (cmd == CMD_LIST) &&
                      in_ch.first_of_list && in_ch.last_of_list) ||
                     ((state_r == ST_RUN) && gcd_rsp.done && emit_r) ||
                     (state_r == ST_HOLD));

  // Value requests pair the operand with the stored divisor; folding list
  // elements pair the running value with the new operand.
  always_comb begin
    gcd_req.start = accept && ((cmd == CMD_VALUE) ||
                               ((cmd == CMD_LIST) && !in_ch.first_of_list));
    if (cmd == CMD_VALUE) begin
      gcd_req.a = mag_of(sext(in_ch.operand));
      gcd_req.b = mag_of(sext(stored_divisor_r));
    end else begin
      gcd_req.a = mag_of(running_value_r);
      gcd_req.b = mag_of(sext(in_ch.operand));
    end
  end

  sgcdf_gcd_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (gcd_req),
    .rsp   (gcd_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      stored_divisor_r <= '0;
      running_value_r  <= '0;
      emit_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      // raise valid on a new result, drop it once the sink has taken it
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_VALUE: begin
                emit_r  <= 1'b1;
                state_r <= ST_RUN;
              end
              CMD_SET_DIV: begin
                stored_divisor_r <= in_ch.operand;
              end
              CMD_LIST: begin
                if (in_ch.first_of_list) begin
                  // load the running value; a lone element goes out unchanged
                  running_value_r <= sext(in_ch.operand);
                  if (in_ch.last_of_list) begin
                    if (slot_free) begin
                      out_data_r <= sext(in_ch.operand);
                    end else begin
                      state_r <= ST_HOLD;
                    end
                  end
                end else begin
                  stored_divisor_r <= in_ch.operand;
                  emit_r           <= in_ch.last_of_list;
                  state_r          <= ST_RUN;
                end
              end
              default: ;  // unused command: ignore
            endcase
          end
        end
        ST_RUN: begin
          if (gcd_rsp.done) begin
            running_value_r <= gcd_rsp.result;
            if (emit_r) begin
              if (slot_free) begin
                out_data_r <= gcd_rsp.result;
                state_r    <= ST_IDLE;
              end else begin
                state_r <= ST_HOLD;
              end
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_HOLD: begin
          // hold the result in the running value until the slot frees
          if (slot_free) begin
            out_data_r <= running_value_r;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.divisor_result = out_data_r;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed gcd fold unit. A short table of directed
// requests covers reset state, operand extremes, zero divisors, list flag
// combinations and the unused command. A long stream of random lists, divisor
// updates and value requests follows. Every result is checked against a
// hand-written value or a cycle-free model of the unit, with random idling on
// both channels and one long receiver hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module tb_top;
  import sgcdf_pkg::*;

  // Unused command code: the unit accepts it and does nothing with it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int N_REQUESTS   = 1325;   // directed rows plus random requests
  localparam int CALM_TAIL    = 150;    // last requests sent with no idling
  localparam int HOLD_AT      = 400;    // request count that triggers the hold-off
  localparam int LONG_HOLD    = 400;    // receiver hold-off length in cycles
  localparam int DRAIN_CYCLES = 3 * (DATA_WIDTH + 1) + 3 + 20;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [1:0] cmd;
    data_t      op;
    logic       first_el;
    logic       last_el;
    bit         typed;    // want holds a hand-written result
    mag_t       want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  sgcdf_in_if  in_ch ();
  sgcdf_out_if out_ch ();

  signed_gcd_fold_unit_core uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the unit's state.
  data_t div_shadow;
  mag_t  run_shadow;

  // Results still owed by the unit, oldest first.
  mag_t  pending_gcd_q[$];

  int    errors      = 0;
  int    n_sent      = 0;
  int    cycle_count = 0;
  bit    calm        = 1'b0;  // set for the tail of the run: no idling at all
  bit    hold_req    = 1'b0;  // ask the receiver for its long hold-off
  bit    hold_on     = 1'b0;  // receiver is in the long hold-off
  bit    tx_gappy    = 1'b1;
  mag_t  want_now;

  // Directed rows. The unit comes out of reset with a zero divisor and a zero
  // running value; expected results are typed only where they are obvious.
  stim_row_t dir_rows [26] = '{
    // zero divisor straight after reset
    '{CMD_VALUE,   32'sd12345,      1'b0, 1'b0, 1'b1, 33'd0},
    // one-element lists give the raw value, sign included
    '{CMD_LIST,    32'sh8000_0000,  1'b1, 1'b1, 1'b1, 33'h1_8000_0000},
    '{CMD_LIST,    32'sh7fff_ffff,  1'b1, 1'b1, 1'b1, 33'h0_7fff_ffff},
    '{CMD_LIST,    -32'sd1,         1'b1, 1'b1, 1'b1, 33'h1_ffff_ffff},
    // explicit zero divisor
    '{CMD_SET_DIV, 32'sd0,          1'b0, 1'b0, 1'b0, 33'd0},
    '{CMD_VALUE,   -32'sd5,         1'b0, 1'b0, 1'b1, 33'd0},
    // most negative divisor: magnitude needs the extra bit
    '{CMD_SET_DIV, 32'sh8000_0000,  1'b0, 1'b0, 1'b0, 33'd0},
    '{CMD_VALUE,   32'sd0,          1'b0, 1'b0, 1'b1, 33'h0_8000_0000},
    '{CMD_VALUE,   32'sh8000_0000,  1'b0, 1'b0, 1'b1, 33'h0_8000_0000},
    '{CMD_VALUE,   32'sh7fff_ffff,  1'b0, 1'b0, 1'b1, 33'd1},
    // list flags are ignored on divisor and value requests
    '{CMD_SET_DIV, -32'sd12,        1'b1, 1'b1, 1'b0, 33'd0},
    '{CMD_VALUE,   32'sd18,         1'b1, 1'b0, 1'b0, 33'd0},
    // unused command leaves the state alone
    '{CMD_UNUSED,  32'sd7,          1'b1, 1'b1, 1'b0, 33'd0},
    '{CMD_VALUE,   32'sd0,          1'b0, 1'b1, 1'b1, 33'd12},
    // list starting at zero, folding through a negative, ending on zero
    '{CMD_LIST,    32'sd0,          1'b1, 1'b0, 1'b0, 33'd0},
    '{CMD_LIST,    -32'sd36,        1'b0, 1'b0, 1'b0, 33'd0},
    '{CMD_LIST,    32'sd24,         1'b0, 1'b0, 1'b0, 33'd0},
    '{CMD_LIST,    32'sd0,          1'b0, 1'b1, 1'b1, 33'd0},
    // the last list element became the divisor
    '{CMD_VALUE,   32'sd99,         1'b0, 1'b0, 1'b1, 33'd0},
    '{CMD_LIST,    32'sh8000_0000,  1'b1, 1'b0, 1'b0, 33'd0},
    '{CMD_LIST,    32'sh8000_0000,  1'b0, 1'b1, 1'b0, 33'd0},
    '{CMD_SET_DIV, 32'sd1,          1'b0, 1'b0, 1'b0, 33'd0},
    '{CMD_VALUE,   32'sh8000_0000,  1'b0, 1'b0, 1'b1, 33'd1},
    '{CMD_LIST,    32'sd100,        1'b1, 1'b0, 1'b0, 33'd0},
    '{CMD_LIST,    32'sd75,         1'b0, 1'b0, 1'b0, 33'd0},
    '{CMD_LIST,    -32'sd10,        1'b0, 1'b1, 1'b0, 33'd0}
  };

  // --------------------------------------------------------------------------
  // Model of the unit
  // --------------------------------------------------------------------------

  // Magnitude of a pattern one bit wider than the data.
  function automatic mag_t mag33(input mag_t v);
    return v[MAG_W-1] ? mag_t'(-v) : v;
  endfunction

  // Euclid on magnitudes; a zero divisor gives zero.
  function automatic mag_t euclid_mag(input mag_t a, input mag_t b);
    mag_t t;
    if (b == '0) return '0;
    while (b != '0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Advance the shadow state by one request; report whether a result is owed.
  task automatic fold_state_step(input logic [1:0] c, input data_t op,
                                 input logic f, input logic l,
                                 output bit emits, output mag_t res);
    mag_t op_wide;
    op_wide = {op[DATA_WIDTH-1], op};
    emits   = 1'b0;
    res     = '0;
    case (c)
      CMD_VALUE: begin
        run_shadow = euclid_mag(mag33(op_wide),
                                mag33({div_shadow[DATA_WIDTH-1], div_shadow}));
        emits = 1'b1;
        res   = run_shadow;
      end
      CMD_SET_DIV: begin
        div_shadow = op;
      end
      CMD_LIST: begin
        if (f) begin
          run_shadow = op_wide;
        end else begin
          // a later element replaces the divisor and folds in
          div_shadow = op;
          run_shadow = euclid_mag(mag33(run_shadow), mag33(op_wide));
        end
        if (l) begin
          emits = 1'b1;
          res   = run_shadow;
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic stim_row_t mk_row(input logic [1:0] c, input data_t op,
                                       input logic f, input logic l);
    stim_row_t r;
    r.cmd      = c;
    r.op       = op;
    r.first_el = f;
    r.last_el  = l;
    r.typed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  // Half the operands are multiples of a shared factor so that the gcd is
  // rarely trivial; zero, extremes and raw random words are mixed in.
  function automatic data_t pick_operand(input int unsigned factor);
    data_t v;
    case ($urandom_range(0, 11))
      0:       v = '0;
      1:       v = 32'sh8000_0000;
      2:       v = 32'sh7fff_ffff;
      3:       v = -32'sd1;
      4, 5:    v = data_t'($urandom);
      default: begin
        v = data_t'(factor * $urandom_range(0, 1 << $urandom_range(0, 12)));
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_factor();
    return $urandom_range(1, 1 << $urandom_range(0, 16)) << $urandom_range(0, 4);
  endfunction

  // Offer one request, hold it until taken, then book the owed result.
  task automatic send_request(input stim_row_t r);
    bit   emits;
    mag_t res;
    if ((n_sent % 50) == 0) tx_gappy = ($urandom_range(0, 2) != 0);
    if (!calm && !hold_on && tx_gappy && $urandom_range(0, 3) == 0) begin
      // idle with junk on the payload
      in_ch.valid         <= 1'b0;
      in_ch.cmd           <= 2'($urandom);
      in_ch.operand       <= data_t'($urandom);
      in_ch.first_of_list <= 1'($urandom);
      in_ch.last_of_list  <= 1'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= r.cmd;
    in_ch.operand       <= r.op;
    in_ch.first_of_list <= r.first_el;
    in_ch.last_of_list  <= r.last_el;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    fold_state_step(r.cmd, r.op, r.first_el, r.last_el, emits, res);
    if (emits) pending_gcd_q.push_back(r.typed ? r.want : res);
    if (r.cmd != CMD_UNUSED) n_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset, watchdog
  // --------------------------------------------------------------------------

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: directed table, then random traffic, then drain and verdict
  // --------------------------------------------------------------------------

  initial begin : sender
    int          pick;
    int          len;
    int unsigned factor;
    stim_row_t   r;

    div_shadow          = '0;
    run_shadow          = '0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_VALUE;
    in_ch.operand       = '0;
    in_ch.first_of_list = 1'b0;
    in_ch.last_of_list  = 1'b0;

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    foreach (dir_rows[i]) send_request(dir_rows[i]);

    while (n_sent < N_REQUESTS) begin
      if (n_sent >= N_REQUESTS - CALM_TAIL) calm = 1'b1;
      if (n_sent >= HOLD_AT && !hold_req && !hold_on && n_sent < HOLD_AT + 5)
        hold_req = 1'b1;
      pick   = $urandom_range(0, 9);
      factor = pick_factor();
      case (pick)
        0, 1, 2, 3, 4: begin
          // well-formed list with a shared factor
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++)
            send_request(mk_row(CMD_LIST, pick_operand(factor), i == 0, i == len - 1));
        end
        5, 6: begin
          // new divisor, then a few values against it
          send_request(mk_row(CMD_SET_DIV, pick_operand(factor),
                              1'($urandom), 1'($urandom)));
          len = $urandom_range(1, 3);
          for (int i = 0; i < len; i++)
            send_request(mk_row(CMD_VALUE, pick_operand(factor),
                                1'($urandom), 1'($urandom)));
        end
        7: begin
          send_request(mk_row(CMD_VALUE, pick_operand(factor),
                              1'($urandom), 1'($urandom)));
        end
        8: begin
          // noise: unused command with random payload
          send_request(mk_row(CMD_UNUSED, data_t'($urandom),
                              1'($urandom), 1'($urandom)));
        end
        default: begin
          // broken list: random flags, possibly interrupted by a value
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0)
              send_request(mk_row(CMD_VALUE, pick_operand(factor), 1'b0, 1'b0));
            send_request(mk_row(CMD_LIST, pick_operand(factor),
                                1'($urandom), 1'($urandom)));
          end
        end
      endcase
    end

    // drop valid on the edge of the last acceptance
    in_ch.valid <= 1'b0;

    while (pending_gcd_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_gcd_q.size() != 0) begin
      $error("divisor_result: %0d expected results never arrived",
             pending_gcd_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver pacing: random stall bursts, one long hold-off, none at the end
  // --------------------------------------------------------------------------

  initial begin : rx_pacing
    int burst_left;
    int hold_left;
    int mode_left;
    bit rx_gappy;

    burst_left   = 0;
    hold_left    = 0;
    mode_left    = 0;
    rx_gappy     = 1'b1;
    out_ch.ready = 1'b0;

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    forever begin
      if (hold_left == 0 && hold_req) begin
        // start the long hold-off; the sender keeps offering meanwhile
        hold_req  = 1'b0;
        hold_on   = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        rx_gappy  = ($urandom_range(0, 2) != 0);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end

      if (hold_left != 0) begin
        hold_left--;
        if (hold_left == 0) hold_on = 1'b0;
        out_ch.ready <= 1'b0;
      end else if (burst_left != 0) begin
        burst_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && rx_gappy && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(1, 8) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each taken result with the oldest owed one
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_gcd_q.size() == 0) begin
        $error("divisor_result: expected none, actual %0d", out_ch.divisor_result);
        errors++;
      end else begin
        want_now = pending_gcd_q.pop_front();
        if (out_ch.divisor_result !== want_now) begin
          $error("divisor_result: expected %0d, actual %0d",
                 $signed(want_now), out_ch.divisor_result);
          errors++;
        end
      end
    end
  end

endmodule
